// ----- design/pim_pkg.sv -----
// shared constants, codes and types for the priority inheritance mutex
package pim_pkg;

  localparam int MaxWaiters = 16;
  localparam int TaskIdBits = 5;
  localparam int PrioBits   = 8;
  localparam int IdxBits    = (MaxWaiters > 1) ? $clog2(MaxWaiters) : 1;
  localparam int CntBits    = $clog2(MaxWaiters + 1);
  localparam int EntryBits  = TaskIdBits + 2 * PrioBits;

  localparam logic [1:0] KIND_LOCK    = 2'd0;
  localparam logic [1:0] KIND_UNLOCK  = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT = 2'd2;
  localparam logic [1:0] KIND_DELETE  = 2'd3;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_UNAVAIL   = 4'd1;
  localparam logic [3:0] ST_QUEUED    = 4'd2;
  localparam logic [3:0] ST_ILLEGAL   = 4'd3;
  localparam logic [3:0] ST_TIMEDOUT  = 4'd4;
  localparam logic [3:0] ST_OWNER     = 4'd5;
  localparam logic [3:0] ST_RELEASED  = 4'd6;
  localparam logic [3:0] ST_FULL      = 4'd7;
  localparam logic [3:0] ST_NOTQUEUED = 4'd8;

  typedef struct packed {
    logic [1:0]            kind;
    logic [TaskIdBits-1:0] task_id;
    logic [PrioBits-1:0]   task_prio;
    logic [PrioBits-1:0]   task_base_prio;
    logic                  may_wait;
  } req_t;

  typedef struct packed {
    logic [3:0]            status;
    logic [TaskIdBits-1:0] subject_task;
    logic                  woken_valid;
    logic [TaskIdBits-1:0] woken_task;
    logic                  owner_valid;
    logic [TaskIdBits-1:0] owner_id;
    logic [PrioBits-1:0]   owner_prio;
    logic                  last;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch request
    logic scan_rd;   // read entry at scan index
    logic scan_clr;  // reset scan index
    logic scan_step; // advance scan index
    logic lock_now;  // take ownership (free mutex)
    logic push;      // append request at tail
    logic inherit;   // owner inherits request priority
    logic mark;      // keep prio of the matched waiter
    logic pop_head;  // latch head as new owner (unlock)
    logic shift;     // write scanned entry one place down
    logic min_init_own;  // min starts at owner base
    logic min_init_head; // min starts at head prio
    logic min_upd;   // fold entry into min
    logic set_eff;   // owner_eff from min
    logic set_eff_np;// owner_eff = head prio
    logic dec;       // waiter_count--
    logic unlock_own;// clear owner registers
    logic clear_q;   // empty the queue
    logic out_load;
    logic [3:0] out_status;
    logic out_sel_entry; // subject from scanned entry
    logic out_woken;
    logic out_last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic kind_lock;
    logic kind_unlock;
    logic kind_timeout;
    logic locked;
    logic is_owner;
    logic may_wait;
    logic full;
    logic empty;
    logic scan_done;   // scan index reached count
    logic entry_match; // registered entry id equals request id
    logic eff_eq_wp;   // owner eff equals removed waiter prio
    logic inherit_en;
  } sts_t;

endpackage

// ----- design/pim_if.sv -----
// valid/ready channel interfaces
interface pim_req_if import pim_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pim_rsp_if import pim_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/pim_ram.sv -----
// generic single-port-write ram with registered read
module pim_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- design/pim_datapath.sv -----
// datapath: owner registers, wait queue memory, scan index and minimum
module pim_datapath import pim_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_data,
  input  req_t       in_data,
  input  cmd_t       cmd,
  output sts_t       sts,
  output rsp_t       rsp
);
  req_t                  req;
  logic                  inherit_en;
  logic                  locked;
  logic [TaskIdBits-1:0] owner_task;
  logic [PrioBits-1:0]   owner_eff;
  logic [PrioBits-1:0]   owner_orig;
  logic [CntBits-1:0]    count;
  logic [CntBits-1:0]    idx;      // address being read
  logic [PrioBits-1:0]   wp;
  logic [PrioBits-1:0]   minp;
  logic [EntryBits-1:0]  rdata;
  logic                  we;
  logic [IdxBits-1:0]    waddr;
  logic [EntryBits-1:0]  wdata;
  logic [TaskIdBits-1:0] e_id;
  logic [PrioBits-1:0]   e_prio;
  logic [PrioBits-1:0]   e_base;
  logic [CntBits-1:0]    dst;

  assign {e_id, e_prio, e_base} = rdata;
  // entry on rdata sits at idx - 1, its new place one below
  assign dst = idx - CntBits'(2);

  // write: push at tail, or shift the entry just read one place down
  always_comb begin
    we    = cmd.push | cmd.shift;
    waddr = cmd.push ? count[IdxBits-1:0] : dst[IdxBits-1:0];
    wdata = cmd.push ? {req.task_id, req.task_prio, req.task_base_prio} : rdata;
  end

  pim_ram #(.Width(EntryBits), .Depth(MaxWaiters)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.scan_rd),
    .raddr (idx[IdxBits-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= in_data;
    end
    if (cmd.min_init_own) begin
      minp <= owner_orig;
    end else if (cmd.min_init_head) begin
      minp <= e_prio;
    end else if (cmd.min_upd && e_prio < minp) begin
      minp <= e_prio;
    end
    if (cmd.out_load) begin
      rsp.status       <= cmd.out_status;
      rsp.subject_task <= cmd.out_sel_entry ? e_id : req.task_id;
      rsp.woken_valid  <= cmd.out_woken;
      rsp.woken_task   <= cmd.out_woken ? owner_task : '0;
      rsp.owner_valid  <= locked;
      rsp.owner_id     <= locked ? owner_task : '0;
      rsp.owner_prio   <= locked ? owner_eff : '0;
      rsp.last         <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inherit_en <= 1'b1;
      locked     <= 1'b0;
      owner_task <= '0;
      owner_eff  <= '0;
      owner_orig <= '0;
      count      <= '0;
      idx        <= '0;
      wp         <= '0;
    end else begin
      if (cfg_we) begin
        inherit_en <= cfg_data;
      end
      if (cmd.scan_clr) begin
        idx <= '0;
      end else if (cmd.scan_step) begin
        idx <= idx + CntBits'(1);
      end
      if (cmd.mark) begin
        wp <= e_prio;
      end
      if (cmd.lock_now) begin
        locked     <= 1'b1;
        owner_task <= req.task_id;
        owner_eff  <= req.task_prio;
        owner_orig <= req.task_base_prio;
      end
      if (cmd.push) begin
        count <= count + CntBits'(1);
      end
      if (cmd.inherit && inherit_en && owner_eff > req.task_prio) begin
        owner_eff <= req.task_prio;
      end
      if (cmd.pop_head) begin
        owner_task <= e_id;
        owner_orig <= e_base;
      end
      if (cmd.set_eff) begin
        owner_eff <= minp;
      end
      if (cmd.set_eff_np) begin
        owner_eff <= e_prio;
      end
      if (cmd.dec) begin
        count <= count - CntBits'(1);
      end
      if (cmd.unlock_own) begin
        locked     <= 1'b0;
        owner_task <= '0;
        owner_eff  <= '0;
        owner_orig <= '0;
      end
      if (cmd.clear_q) begin
        count <= '0;
      end
    end
  end

  assign sts.kind_lock    = req.kind == KIND_LOCK;
  assign sts.kind_unlock  = req.kind == KIND_UNLOCK;
  assign sts.kind_timeout = req.kind == KIND_TIMEOUT;
  assign sts.locked       = locked;
  assign sts.is_owner     = owner_task == req.task_id;
  assign sts.may_wait     = req.may_wait;
  assign sts.full         = count >= CntBits'(MaxWaiters);
  assign sts.empty        = count == '0;
  assign sts.scan_done    = idx >= count;
  assign sts.entry_match  = e_id == req.task_id;
  assign sts.eff_eq_wp    = owner_eff == wp;
  assign sts.inherit_en   = inherit_en;
endmodule

// ----- design/pim_ctrl.sv -----
// controller state machine sequencing the queue scans
module pim_ctrl import pim_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_FIND    = 4'd2;  // lock / timeout search
  localparam logic [3:0] S_TOSHIFT = 4'd3;  // timeout: close the gap
  localparam logic [3:0] S_TOMIN   = 4'd4;
  localparam logic [3:0] S_TOMIN2  = 4'd5;
  localparam logic [3:0] S_MINSCAN = 4'd6;
  localparam logic [3:0] S_SETEFF  = 4'd7;
  localparam logic [3:0] S_HEAD    = 4'd8;  // unlock: head data ready
  localparam logic [3:0] S_SHIFT   = 4'd9;  // shift down + min
  localparam logic [3:0] S_SHLAST  = 4'd10;
  localparam logic [3:0] S_DEL     = 4'd11;
  localparam logic [3:0] S_OUT     = 4'd12;

  logic [3:0] state, state_next;
  logic [3:0] status, status_next;
  logic       woke, woke_next;
  logic       busy;
  logic       slot;

  assign out_valid = busy;
  assign in_ready  = state == S_IDLE;
  // one result register: a new result loads only once the old is gone
  assign slot      = !busy || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      status <= ST_OK;
      woke   <= 1'b0;
      busy   <= 1'b0;
    end else begin
      state  <= state_next;
      status <= status_next;
      woke   <= woke_next;
      if (cmd.out_load) begin
        busy <= 1'b1;
      end else if (out_ready) begin
        busy <= 1'b0;
      end
    end
  end

  always_comb begin
    cmd         = '0;
    state_next  = state;
    status_next = status;
    woke_next   = woke;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load     = 1'b1;
          cmd.scan_clr = 1'b1;
          woke_next    = 1'b0;
          state_next   = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.kind_lock) begin
          if (!sts.locked) begin
            cmd.lock_now = 1'b1;
            status_next  = ST_OK;
            state_next   = S_OUT;
          end else if (sts.is_owner) begin
            status_next = ST_OWNER;
            state_next  = S_OUT;
          end else if (sts.empty) begin
            state_next = S_OUT;
            if (!sts.may_wait) begin
              status_next = ST_UNAVAIL;
            end else begin
              cmd.push    = 1'b1;
              cmd.inherit = 1'b1;
              status_next = ST_QUEUED;
            end
          end else begin
            cmd.scan_rd   = 1'b1;
            cmd.scan_step = 1'b1;
            state_next    = S_FIND;
          end
        end else if (sts.kind_unlock) begin
          status_next = ST_OK;
          if (!sts.locked) begin
            state_next = S_OUT;
          end else if (!sts.is_owner) begin
            status_next = ST_ILLEGAL;
            state_next  = S_OUT;
          end else if (sts.empty) begin
            cmd.unlock_own = 1'b1;
            state_next     = S_OUT;
          end else begin
            cmd.scan_rd   = 1'b1;
            cmd.scan_step = 1'b1;
            woke_next     = 1'b1;
            state_next    = S_HEAD;
          end
        end else if (sts.kind_timeout) begin
          if (sts.locked && sts.is_owner) begin
            status_next = ST_OK;
            state_next  = S_OUT;
          end else if (sts.empty) begin
            status_next = ST_NOTQUEUED;
            state_next  = S_OUT;
          end else begin
            cmd.scan_rd   = 1'b1;
            cmd.scan_step = 1'b1;
            state_next    = S_FIND;
          end
        end else begin
          // delete: released beats already show the mutex unlocked
          cmd.unlock_own = 1'b1;
          if (sts.empty) begin
            status_next = ST_OK;
            state_next  = S_OUT;
          end else begin
            cmd.scan_rd   = 1'b1;
            cmd.scan_step = 1'b1;
            state_next    = S_DEL;
          end
        end
      end
      S_FIND: begin
        // entry at idx-1 is on rdata
        if (sts.entry_match) begin
          if (sts.kind_lock) begin
            status_next = ST_QUEUED;
            state_next  = S_OUT;
          end else begin
            cmd.mark    = 1'b1;
            status_next = ST_TIMEDOUT;
            if (!sts.scan_done) begin
              cmd.scan_rd   = 1'b1;
              cmd.scan_step = 1'b1;
              state_next    = S_TOSHIFT;
            end else begin
              state_next = S_TOMIN;
            end
          end
        end else if (!sts.scan_done) begin
          cmd.scan_rd   = 1'b1;
          cmd.scan_step = 1'b1;
        end else begin
          state_next = S_OUT;
          if (!sts.kind_lock) begin
            status_next = ST_NOTQUEUED;
          end else if (!sts.may_wait) begin
            status_next = ST_UNAVAIL;
          end else if (sts.full) begin
            status_next = ST_FULL;
          end else begin
            cmd.push    = 1'b1;
            cmd.inherit = 1'b1;
            status_next = ST_QUEUED;
          end
        end
      end
      S_TOSHIFT: begin
        cmd.shift = 1'b1;
        if (!sts.scan_done) begin
          cmd.scan_rd   = 1'b1;
          cmd.scan_step = 1'b1;
        end else begin
          state_next = S_TOMIN;
        end
      end
      S_TOMIN: begin
        cmd.dec = 1'b1;
        if (sts.inherit_en && sts.locked && sts.eff_eq_wp) begin
          cmd.scan_clr     = 1'b1;
          cmd.min_init_own = 1'b1;
          state_next       = S_TOMIN2;
        end else begin
          state_next = S_OUT;
        end
      end
      S_TOMIN2: begin
        if (!sts.scan_done) begin
          cmd.scan_rd   = 1'b1;
          cmd.scan_step = 1'b1;
          state_next    = S_MINSCAN;
        end else begin
          state_next = S_SETEFF;
        end
      end
      S_MINSCAN: begin
        // scan remaining entries for minimum
        cmd.min_upd = 1'b1;
        if (!sts.scan_done) begin
          cmd.scan_rd   = 1'b1;
          cmd.scan_step = 1'b1;
        end else begin
          state_next = S_SETEFF;
        end
      end
      S_SETEFF: begin
        cmd.set_eff = 1'b1;
        state_next  = S_OUT;
      end
      S_HEAD: begin
        cmd.pop_head      = 1'b1;
        cmd.min_init_head = 1'b1;
        if (!sts.inherit_en) begin
          cmd.set_eff_np = 1'b1;
        end
        if (!sts.scan_done) begin
          cmd.scan_rd   = 1'b1;
          cmd.scan_step = 1'b1;
          state_next    = S_SHIFT;
        end else begin
          state_next = S_SHLAST;
        end
      end
      S_SHIFT: begin
        cmd.shift   = 1'b1;
        cmd.min_upd = 1'b1;
        if (!sts.scan_done) begin
          cmd.scan_rd   = 1'b1;
          cmd.scan_step = 1'b1;
        end else begin
          state_next = S_SHLAST;
        end
      end
      S_SHLAST: begin
        cmd.dec = 1'b1;
        if (sts.inherit_en) begin
          cmd.set_eff = 1'b1;
        end
        state_next = S_OUT;
      end
      S_DEL: begin
        if (slot) begin
          cmd.out_load      = 1'b1;
          cmd.out_status    = ST_RELEASED;
          cmd.out_sel_entry = 1'b1;
          cmd.out_last      = sts.scan_done;
          if (!sts.scan_done) begin
            cmd.scan_rd   = 1'b1;
            cmd.scan_step = 1'b1;
          end else begin
            cmd.clear_q = 1'b1;
            state_next  = S_IDLE;
          end
        end
      end
      S_OUT: begin
        if (slot) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = status;
          cmd.out_woken  = woke;
          cmd.out_last   = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule

// ----- design/priority_inheritance_mutex.sv -----
// Priority inheritance mutex: one item at a time. Every item passes through
// idle and dispatch; a lock by the owner or on a free mutex then goes
// straight to the output state. A lock on a busy mutex compares the wait
// queue one entry per cycle through its registered-read memory; an unlock
// hands over to the head waiter and shifts the rest down; a timeout removes a
// waiter and, when inheritance is on and the owner held that waiter's
// priority, rescans the queue for the minimum; delete gives one released
// beat per cycle while the sink takes them. A result waiting on the sink
// holds the block.
// Configuration should be written only while the block is idle.
module priority_inheritance_mutex import pim_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   cfg_we,
  input  logic   cfg_data,
  pim_req_if.sink   in_ch,
  pim_rsp_if.source out_ch
);
  cmd_t cmd;
  sts_t sts;

  pim_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pim_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_data  (in_ch.data),
    .cmd      (cmd),
    .sts      (sts),
    .rsp      (out_ch.data)
  );

  // a result never loads over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |-> !cmd.out_load)
    else $error("result overwritten");

  // never append to a full queue
  a_push_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !sts.full)
    else $error("push into full queue");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !(cmd.push && cmd.shift))
    else $error("two queue writes");
endmodule
